@@ hw/rtl/rcgm_pkg.sv @@
// ----------------------------------------------------------------------------
// rcgm_pkg: shared types and constants of the RC channel to gamepad mapper
// Register indexes, reset values and field widths used by the mapper.
// ----------------------------------------------------------------------------
package rcgm_pkg;

    // field widths
    localparam int unsigned PW_W      = 12;   // pulse width / axis value
    localparam int unsigned HYST_W    = 11;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned NUM_CH    = 8;
    localparam int unsigned AXIS_CNT  = 4;
    localparam int unsigned NUM_BTNS  = 5;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 12;

    // stream payload widths (packed, padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 64;

    // signed working width for threshold and inversion math
    localparam int unsigned SW = PW_W + 2;

    localparam logic [PW_W-1:0] PW_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_MIN    = 8'd0,
        REG_AXIS_MAX    = 8'd1,
        REG_AXIS_CENTER = 8'd2,
        REG_DEADBAND    = 8'd3,
        REG_BTN_THR     = 8'd4,
        REG_HYST        = 8'd5,
        REG_SW_LOW      = 8'd6,
        REG_SW_HIGH     = 8'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [PW_W-1:0]   RST_AXIS_MIN    = 12'd1000;
    localparam logic [PW_W-1:0]   RST_AXIS_MAX    = 12'd2000;
    localparam logic [PW_W-1:0]   RST_AXIS_CENTER = 12'd1500;
    localparam logic [PW_W-1:0]   RST_DEADBAND    = 12'd4;
    localparam logic [PW_W-1:0]   RST_BTN_THR     = 12'd1500;
    localparam logic [HYST_W-1:0] RST_HYST        = 11'd50;
    localparam logic [PW_W-1:0]   RST_SW_LOW      = 12'd1300;
    localparam logic [PW_W-1:0]   RST_SW_HIGH     = 12'd1700;

    // function code carried in tuser
    typedef enum logic {
        FUNC_FRAME   = 1'b0,
        FUNC_NEUTRAL = 1'b1
    } t_func;

    // one accepted frame request
    typedef struct packed {
        t_func                     func;
        logic [CNT_W-1:0]          live_ch;
        logic [NUM_CH-1:0][PW_W-1:0] ch;
    } t_frame;

    // configuration set
    typedef struct packed {
        logic [PW_W-1:0]   axis_min;
        logic [PW_W-1:0]   axis_max;
        logic [PW_W-1:0]   axis_center;
        logic [PW_W-1:0]   deadband;
        logic [PW_W-1:0]   btn_thr;
        logic [HYST_W-1:0] hyst;
        logic [PW_W-1:0]   sw_low;
        logic [PW_W-1:0]   sw_high;
    } t_cfg;

endpackage

@@ hw/rtl/rc_channel_to_gamepad_mapper_unit.sv @@
// Path: an accepted input request is held in the input register, then in
//   the result register, from which m_axis offers its result.
// Throughput: 1 frame per cycle unless m_axis_tready stalls the result
//   register; set by the single compare/update pass between the registers.
// Reset (i_rst_n low, synchronous): registers take their defaults, axes
//   go to 1500, buttons released, both pipeline stages empty.
// ----------------------------------------------------------------------------
// rc_channel_to_gamepad_mapper_unit: RC pulse widths to gamepad state
// Maps up to eight RC channels to four deadbanded axes and five buttons
// with hysteresis; a neutral command recenters axes and releases buttons.
// ----------------------------------------------------------------------------
module rc_channel_to_gamepad_mapper_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // frame input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: live_ch[3:0], ch1_us..ch8_us (12 bits each), zero pad
    input  logic [rcgm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: func
    input  logic                                s_axis_tuser,
    // result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: axis_x, axis_y, axis_rx, axis_ry (12 bits each),
    // button_bits[4:0], axis_changed[3:0], button_changed[4:0], zero pad
    output logic [rcgm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rcgm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcgm_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import rcgm_pkg::*;

    // absolute difference meets deadband
    function automatic logic axis_hit(input logic [PW_W-1:0] v,
                                      input logic [PW_W-1:0] stored,
                                      input logic [PW_W-1:0] dband);
        logic [PW_W-1:0] d;
        d = (v >= stored) ? (v - stored) : (stored - v);
        return d >= dband;
    endfunction

    // next button state through threshold with hysteresis
    function automatic logic btn_next(input logic [PW_W-1:0] raw,
                                      input logic [PW_W-1:0] thr,
                                      input logic [HYST_W-1:0] h,
                                      input logic cur);
        logic signed [SW-1:0] lim;
        logic signed [SW-1:0] r;
        r   = signed'({2'b00, raw});
        lim = cur ? (signed'({2'b00, thr}) - signed'({3'b000, h}))
                  : (signed'({2'b00, thr}) + signed'({3'b000, h}));
        return r > lim;
    endfunction

    t_cfg   r_cfg;
    t_frame r_in;
    logic   r_in_vld;
    logic   r_out_vld;
    logic [OUT_DATA_W-1:0] r_out;

    logic [AXIS_CNT-1:0][PW_W-1:0] r_axis;
    logic [NUM_BTNS-1:0]           r_btn;

    logic [AXIS_CNT-1:0][PW_W-1:0] n_axis;
    logic [NUM_BTNS-1:0]           n_btn;
    logic [AXIS_CNT-1:0]           achg;
    logic [NUM_BTNS-1:0]           bchg;
    logic [AXIS_CNT-1:0][PW_W-1:0] axis_in;
    logic [AXIS_CNT-1:0]           axis_en;
    logic [NUM_BTNS-1:0][PW_W-1:0] btn_in;
    logic [NUM_BTNS-1:0][PW_W-1:0] btn_thr;
    logic [NUM_BTNS-1:0]           btn_en;
    logic signed [SW-1:0]          inv;
    logic                          adv;

    // handshakes
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_min    <= RST_AXIS_MIN;
            r_cfg.axis_max    <= RST_AXIS_MAX;
            r_cfg.axis_center <= RST_AXIS_CENTER;
            r_cfg.deadband    <= RST_DEADBAND;
            r_cfg.btn_thr     <= RST_BTN_THR;
            r_cfg.hyst        <= RST_HYST;
            r_cfg.sw_low      <= RST_SW_LOW;
            r_cfg.sw_high     <= RST_SW_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AXIS_MIN:    r_cfg.axis_min    <= i_cfg_data;
                REG_AXIS_MAX:    r_cfg.axis_max    <= i_cfg_data;
                REG_AXIS_CENTER: r_cfg.axis_center <= i_cfg_data;
                REG_DEADBAND:    r_cfg.deadband    <= i_cfg_data;
                REG_BTN_THR:     r_cfg.btn_thr     <= i_cfg_data;
                REG_HYST:        r_cfg.hyst        <= i_cfg_data[HYST_W-1:0];
                REG_SW_LOW:      r_cfg.sw_low      <= i_cfg_data;
                REG_SW_HIGH:     r_cfg.sw_high     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.func    <= t_func'(s_axis_tuser);
            r_in.live_ch <= s_axis_tdata[CNT_W-1:0];
            for (int i = 0; i < NUM_CH; i++) begin
                r_in.ch[i] <= s_axis_tdata[CNT_W + i*PW_W +: PW_W];
            end
        end
    end

    // channel routing and enables
    always_comb begin
        inv = signed'({2'b00, r_cfg.axis_min}) + signed'({2'b00, r_cfg.axis_max})
            - signed'({2'b00, r_in.ch[1]});
        axis_in[0] = r_in.ch[0];
        if (inv < 0) begin
            axis_in[1] = '0;
        end else if (inv > signed'({2'b00, PW_MAX})) begin
            axis_in[1] = PW_MAX;
        end else begin
            axis_in[1] = inv[PW_W-1:0];
        end
        axis_in[2] = r_in.ch[4];
        axis_in[3] = r_in.ch[5];
        axis_en[0] = r_in.live_ch >= 4'd1;
        axis_en[1] = r_in.live_ch >= 4'd2;
        axis_en[2] = r_in.live_ch >= 4'd5;
        axis_en[3] = r_in.live_ch >= 4'd6;

        btn_in[0]  = r_in.ch[2];
        btn_in[1]  = r_in.ch[3];
        btn_in[2]  = r_in.ch[6];
        btn_in[3]  = r_in.ch[6];
        btn_in[4]  = r_in.ch[7];
        btn_thr[0] = r_cfg.btn_thr;
        btn_thr[1] = r_cfg.btn_thr;
        btn_thr[2] = r_cfg.sw_low;
        btn_thr[3] = r_cfg.sw_high;
        btn_thr[4] = r_cfg.btn_thr;
        btn_en[0]  = r_in.live_ch >= 4'd3;
        btn_en[1]  = r_in.live_ch >= 4'd4;
        btn_en[2]  = r_in.live_ch >= 4'd7;
        btn_en[3]  = r_in.live_ch >= 4'd7;
        btn_en[4]  = r_in.live_ch >= 4'd8;
    end

    // axis and button update
    always_comb begin
        n_axis = r_axis;
        n_btn  = r_btn;
        achg   = '0;
        bchg   = '0;
        if (r_in.func == FUNC_NEUTRAL) begin
            for (int a = 0; a < AXIS_CNT; a++) begin
                n_axis[a] = r_cfg.axis_center;
            end
            achg  = '1;
            bchg  = r_btn;
            n_btn = '0;
        end else begin
            for (int a = 0; a < AXIS_CNT; a++) begin
                if (axis_en[a] && axis_hit(axis_in[a], r_axis[a], r_cfg.deadband)) begin
                    n_axis[a] = axis_in[a];
                    achg[a]   = 1'b1;
                end
            end
            for (int b = 0; b < NUM_BTNS; b++) begin
                if (btn_en[b]) begin
                    n_btn[b] = btn_next(btn_in[b], btn_thr[b], r_cfg.hyst, r_btn[b]);
                    bchg[b]  = n_btn[b] ^ r_btn[b];
                end
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXIS_CNT; a++) begin
                r_axis[a] <= RST_AXIS_CENTER;
            end
            r_btn     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_axis    <= n_axis;
                r_btn     <= n_btn;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {2'b00, bchg, achg, n_btn,
                      n_axis[3], n_axis[2], n_axis[1], n_axis[0]};
        end
    end

endmodule
